/* hw/rtl/mnp_pkg.sv */
// package for the midi note on/off pairing block
// event codes, record kinds, field widths and parameter defaults; no dependencies
`timescale 1ns / 1ps

package mnp_pkg;

    // parameter defaults
    localparam int DEF_NUM_PITCHES = 128;
    localparam int DEF_TIME_BITS   = 40;

    // fixed field widths
    localparam int CMD_W      = 2;
    localparam int DELTA_W    = 28;
    localparam int VALUE_W    = 7;
    localparam int VEL_W      = 7;
    localparam int OUT_TIME_W = 40;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 96;

    // event kinds on the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_DAMPER   = 2'd2
    } cmd_t;

    // record kinds on the output tuser
    localparam logic REC_NOTE   = 1'b0;
    localparam logic REC_DAMPER = 1'b1;

    // damper pedal positions carried in value1
    localparam logic [VALUE_W-1:0] PEDAL_UP   = 7'd0;
    localparam logic [VALUE_W-1:0] PEDAL_DOWN = 7'd1;

endpackage

/* hw/rtl/mnp_ram.sv */
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`timescale 1ns / 1ps

module mnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/midi_note_on_off_pairing.sv */
// top level of the midi note on/off pairing block
// depends on mnp_pkg and the generic ram mnp_ram
`timescale 1ns / 1ps

// Pairs timed note on, note off and damper pedal events into finished note
// and damper records. Every input item adds its delta to a running tick total
// that saturates at 2^TIME_BITS-1. A note on stores start time and volume for
// its pitch in a ram and sets the pitch's active flag (flags are flip-flops
// cleared by reset, so there is no clearing pass); a note off for an active
// pitch reads that entry back and sends a note record; a pedal release after
// a press sends a damper record. One item is taken every clock cycle while the
// master side keeps up: an item's record is registered first in stage 1, with
// the ram read, and then in the output register before it leaves. Under
// output backpressure the output register and the stage behind it hold one
// record each; once both are full the slave side waits until the output item
// is taken, whatever the waiting input item is. The ram does one write and one
// read per cycle, which sets the rate of one item per cycle. Times leave as 40
// bit values, truncated or zero extended from TIME_BITS. Records leave in the
// order their items arrived; items that finish nothing give no record.

module midi_note_on_off_pairing
    import mnp_pkg::*;
#(
    parameter int NUM_PITCHES = DEF_NUM_PITCHES,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // delta_ticks[27:0], value1[34:28], velocity[41:35]
    input  logic [CMD_W-1:0]    s_tuser,  // cmd[1:0]
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // note_pitch[6:0], note_volume[13:7],
                                          // start_ticks[53:14], stop_ticks[93:54]
    output logic                m_tuser   // record_kind[0]
);

    localparam int IDX_W   = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1;
    localparam int ENTRY_W = TIME_BITS + VEL_W;

    // input field unpacking
    logic                 accept;
    cmd_t                 in_cmd;
    logic [DELTA_W-1:0]   in_delta;
    logic [VALUE_W-1:0]   in_value1;
    logic [VEL_W-1:0]     in_velocity;
    logic [7:0]           in_value1_ext;
    logic [IDX_W-1:0]     in_idx;
    logic                 in_range;

    assign accept        = s_tvalid && s_tready;
    assign in_cmd        = cmd_t'(s_tuser);
    assign in_delta      = s_tdata[DELTA_W-1:0];
    assign in_value1     = s_tdata[DELTA_W +: VALUE_W];
    assign in_velocity   = s_tdata[DELTA_W+VALUE_W +: VEL_W];
    // pitch index, value1 zero extended to eight bits before the select
    assign in_value1_ext = {1'b0, in_value1};
    assign in_idx        = in_value1_ext[IDX_W-1:0];
    assign in_range      = {2'b00, in_value1} < 9'(NUM_PITCHES);

    // running tick total, saturating add
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS:0]   elapsed_sum;
    logic [TIME_BITS-1:0] elapsed_new;

    assign elapsed_sum  = {1'b0, elapsed_reg} + (TIME_BITS+1)'(in_delta);
    assign elapsed_new  = elapsed_sum[TIME_BITS] ? '1 : elapsed_sum[TIME_BITS-1:0];
    assign elapsed_next = accept ? elapsed_new : elapsed_reg;

    // per-pitch active flags and damper state
    logic [NUM_PITCHES-1:0] pitch_active_reg, pitch_active_next;
    logic                   pedal_active_reg, pedal_active_next;
    logic [TIME_BITS-1:0]   pedal_start_reg;

    // event decode
    logic note_wr;
    logic note_done;
    logic pedal_down;
    logic pedal_done;

    always_comb
    begin
        note_wr    = 1'b0;
        note_done  = 1'b0;
        pedal_down = 1'b0;
        pedal_done = 1'b0;
        unique case (in_cmd)
            CMD_NOTE_ON:
            begin
                note_wr = accept && in_range;
            end
            CMD_NOTE_OFF:
            begin
                note_done = accept && in_range && pitch_active_reg[in_idx];
            end
            CMD_DAMPER:
            begin
                pedal_down = accept && !pedal_active_reg && (in_value1 == PEDAL_DOWN);
                pedal_done = accept && pedal_active_reg && (in_value1 == PEDAL_UP);
            end
            default:
            begin
                // unused code only advances time
            end
        endcase
    end

    always_comb
    begin
        pitch_active_next = pitch_active_reg;
        if (note_wr)
        begin
            pitch_active_next[in_idx] = 1'b1;
        end
        else if (note_done)
        begin
            pitch_active_next[in_idx] = 1'b0;
        end
    end

    always_comb
    begin
        pedal_active_next = pedal_active_reg;
        if (pedal_down)
        begin
            pedal_active_next = 1'b1;
        end
        else if (pedal_done)
        begin
            pedal_active_next = 1'b0;
        end
    end

    // start time and volume per pitch; a write commits at the accepting edge,
    // so a read issued by any later item already sees it
    logic [ENTRY_W-1:0] ram_rdata;

    mnp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_PITCHES)
    ) u_note_ram (
        .clk  (clk),
        .we   (note_wr),
        .waddr(in_idx),
        .wdata({elapsed_new, in_velocity}),
        .re   (note_done),
        .raddr(in_idx),
        .rdata(ram_rdata)
    );

    // stage 1: record waiting for ram data
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_kind_reg;
    logic [VALUE_W-1:0]   s1_pitch_reg;
    logic [TIME_BITS-1:0] s1_start_reg;
    logic [TIME_BITS-1:0] s1_stop_reg;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_kind_reg;
    logic [VALUE_W-1:0]    out_pitch_reg;
    logic [VEL_W-1:0]      out_volume_reg;
    logic [OUT_TIME_W-1:0] out_start_reg;
    logic [OUT_TIME_W-1:0] out_stop_reg;

    logic out_load;
    logic s1_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s1_load  = !s1_valid_reg || out_load;
    assign s_tready = s1_load;

    assign s1_valid_next  = s1_load ? (note_done || pedal_done) : s1_valid_reg;
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    // record fields from stage 1
    logic [TIME_BITS-1:0]  rec_start;
    logic [VALUE_W-1:0]    rec_pitch;
    logic [VEL_W-1:0]      rec_volume;
    logic [OUT_TIME_W-1:0] rec_start_out;
    logic [OUT_TIME_W-1:0] rec_stop_out;

    always_comb
    begin
        if (s1_kind_reg == REC_DAMPER)
        begin
            rec_start  = s1_start_reg;
            rec_pitch  = '0;
            rec_volume = '0;
        end
        else
        begin
            rec_start  = ram_rdata[VEL_W +: TIME_BITS];
            rec_pitch  = s1_pitch_reg;
            rec_volume = ram_rdata[VEL_W-1:0];
        end
    end

    // times leave at 40 bits
    generate
        if (TIME_BITS >= OUT_TIME_W)
        begin : g_time_trunc
            assign rec_start_out = rec_start[OUT_TIME_W-1:0];
            assign rec_stop_out  = s1_stop_reg[OUT_TIME_W-1:0];
        end
        else
        begin : g_time_ext
            assign rec_start_out = {{(OUT_TIME_W-TIME_BITS){1'b0}}, rec_start};
            assign rec_stop_out  = {{(OUT_TIME_W-TIME_BITS){1'b0}}, s1_stop_reg};
        end
    endgenerate

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg      <= '0;
            pitch_active_reg <= '0;
            pedal_active_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            elapsed_reg      <= elapsed_next;
            pitch_active_reg <= pitch_active_next;
            pedal_active_reg <= pedal_active_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pedal_down)
        begin
            pedal_start_reg <= elapsed_new;
        end
        if (s1_load)
        begin
            s1_kind_reg  <= pedal_done ? REC_DAMPER : REC_NOTE;
            s1_pitch_reg <= in_value1;
            s1_start_reg <= pedal_start_reg;
            s1_stop_reg  <= elapsed_new;
        end
        if (out_load && s1_valid_reg)
        begin
            out_kind_reg   <= s1_kind_reg;
            out_pitch_reg  <= rec_pitch;
            out_volume_reg <= rec_volume;
            out_start_reg  <= rec_start_out;
            out_stop_reg   <= rec_stop_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_stop_reg, out_start_reg, out_volume_reg, out_pitch_reg};

    // a finished note leaves its pitch inactive
    a_note_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
        note_done |=> !pitch_active_reg[$past(in_idx)])
        else $error("active flag still set after note off");

    // the tick total never runs backward
    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> elapsed_reg >= $past(elapsed_reg))
        else $error("tick total decreased");

    // a damper record in flight means the pedal is released
    a_damper_released: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_kind_reg == REC_DAMPER) |-> !pedal_active_reg)
        else $error("damper record while pedal pressed");

endmodule
